### sv/avd_pkg.sv
// Shared types, constants and the seven-segment lookup for the voltmeter display.
// No dependencies; every other file of the block imports this package.
package avd_pkg;

  // Item kind carried on in_tuser
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } avd_op_t;

  localparam int SAMPLE_W     = 12;
  localparam int PROD_W       = 24;   // sample * 3300 fits in 24 bits
  localparam int MV_W         = 12;   // millivolts, at most 3300
  localparam int DIGITS_MAX   = 4;    // decimal digits a millivolt value can have
  localparam int SEG_W        = 8;
  localparam int SEL_OUT_W    = 4;
  localparam int NUM_DIGITS_D = 4;

  localparam logic [PROD_W-1:0] MV_SCALE  = 24'd3300;
  localparam logic [12:0]       FULL_CODE = 13'd4095;
  localparam logic [SEG_W-1:0]  SEG_ZERO  = 8'hc0;

  // Pipeline control that travels with each beat
  typedef struct packed {
    logic vld;
    logic tick;
  } avd_ctl_t;

  // Decimal digits, index 3 is thousands, index 0 is units
  typedef logic [DIGITS_MAX-1:0][3:0] avd_digits_t;

  // Active-low segment pattern, decimal point off
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h98;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

endpackage

### sv/adc_voltmeter_display_scan.sv
// Top level of the multiplexed seven-segment voltmeter display.
// Depends on avd_pkg, avd_scale, avd_digits and avd_display.
//
//   channel | ports                      | payload
//   --------+----------------------------+---------------------------------------
//   input   | in_tvalid/in_tready        | in_tdata: sample; in_tuser: op
//   result  | out_tvalid/out_tready      | out_tdata: segment_code, digit_select
//
// One beat is taken per cycle while in_tready is high, through a five-register
// pipeline (input, product, millivolts, digits, result). Ticks and changed
// samples pass the input to digits registers; a tick then sets out_tvalid and
// a sample updates the stored codes. Reset (rst_n low, synchronous) empties
// the pipeline and shows zero on all digits. A stalled result only holds back
// ticks; in_tready drops once every stage upstream of a waiting tick is full.
module adc_voltmeter_display_scan
  import avd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_D
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, [15:12] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] segment_code, [11:8] digit_select, [15:12] zero
);

  avd_ctl_t             s1_ctl_r;
  avd_ctl_t             s1_ctl_nxt;
  logic [SAMPLE_W-1:0]  s1_sample_r;
  logic [SAMPLE_W-1:0]  last_sample_r;
  logic                 s1_ready;
  logic                 in_fire;
  logic                 is_tick;
  logic                 sample_changed;
  avd_ctl_t             scale_ctl;
  logic [MV_W-1:0]      scale_mv;
  logic                 scale_ready;
  avd_ctl_t             dig_ctl;
  avd_digits_t          dig_digits;
  logic                 dig_ready;
  logic                 disp_ready;
  logic [SEG_W-1:0]     seg;
  logic [SEL_OUT_W-1:0] sel;

  assign s1_ready  = !s1_ctl_r.vld || scale_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && s1_ready;
  assign is_tick   = (avd_op_t'(in_tuser) == OP_TICK);

  // Drop samples equal to the kept one here, so only real updates travel on
  assign sample_changed = (in_tdata[SAMPLE_W-1:0] != last_sample_r);

  always_comb begin
    s1_ctl_nxt.vld  = in_fire && (is_tick || sample_changed);
    s1_ctl_nxt.tick = is_tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r      <= '0;
      last_sample_r <= '0;
    end else begin
      if (s1_ready) s1_ctl_r <= s1_ctl_nxt;
      if (in_fire && !is_tick) last_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1_sample_r <= in_tdata[SAMPLE_W-1:0];
  end

  avd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (s1_ctl_r),
    .up_sample (s1_sample_r),
    .up_ready  (scale_ready),
    .dn_ctl    (scale_ctl),
    .dn_mv     (scale_mv),
    .dn_ready  (dig_ready)
  );

  avd_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (scale_ctl),
    .up_mv     (scale_mv),
    .up_ready  (dig_ready),
    .dn_ctl    (dig_ctl),
    .dn_digits (dig_digits),
    .dn_ready  (disp_ready)
  );

  avd_display #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_display (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (dig_ctl),
    .up_digits (dig_digits),
    .up_ready  (disp_ready),
    .out_valid (out_tvalid),
    .out_seg   (seg),
    .out_sel   (sel),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'b0000, sel, seg};

endmodule

### sv/avd_scale.sv
// Two pipeline stages that scale a sample to millivolts (sample*3300/4095, truncated).
// Depends on avd_pkg.
module avd_scale
  import avd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  avd_ctl_t            up_ctl,
  input  logic [SAMPLE_W-1:0] up_sample,
  output logic                up_ready,
  output avd_ctl_t            dn_ctl,
  output logic [MV_W-1:0]     dn_mv,
  input  logic                dn_ready
);

  avd_ctl_t            s2_ctl_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [PROD_W-1:0]   s2_prod_nxt;
  avd_ctl_t            s3_ctl_r;
  logic [MV_W-1:0]     s3_mv_r;
  logic [MV_W-1:0]     s3_mv_nxt;
  logic                s2_ready;
  logic                s3_ready;
  logic [MV_W-1:0]     prod_hi;
  logic [12:0]         fold_sum;

  // Advance a stage when it is empty or the next one takes its beat
  assign s3_ready = !s3_ctl_r.vld || dn_ready;
  assign s2_ready = !s2_ctl_r.vld || s3_ready;
  assign up_ready = s2_ready;

  // Constant multiply by 3300
  assign s2_prod_nxt = {{(PROD_W-SAMPLE_W){1'b0}}, up_sample} * MV_SCALE;

  // Divide by 4095: x = a*4096 + b = a*4095 + (a+b), and a+b < 2*4095
  assign prod_hi  = s2_prod_r[PROD_W-1:SAMPLE_W];
  assign fold_sum = {1'b0, prod_hi} + {1'b0, s2_prod_r[SAMPLE_W-1:0]};
  assign s3_mv_nxt = prod_hi + {{(MV_W-1){1'b0}}, (fold_sum >= FULL_CODE)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      if (s2_ready) s2_ctl_r <= up_ctl;
      if (s3_ready) s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) s2_prod_r <= s2_prod_nxt;
    if (s3_ready) s3_mv_r   <= s3_mv_nxt;
  end

  assign dn_ctl = s3_ctl_r;
  assign dn_mv  = s3_mv_r;

endmodule

### sv/avd_digits.sv
// Pipeline stage that splits a millivolt value into four decimal digits.
// Depends on avd_pkg; reciprocal multiplies are exact for values up to 3300.
module avd_digits
  import avd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  avd_ctl_t        up_ctl,
  input  logic [MV_W-1:0] up_mv,
  output logic            up_ready,
  output avd_ctl_t        dn_ctl,
  output avd_digits_t     dn_digits,
  input  logic            dn_ready
);

  avd_ctl_t     s4_ctl_r;
  avd_digits_t  s4_digits_r;
  avd_digits_t  digits_nxt;
  logic         s4_ready;
  logic [24:0]  prod_1000;
  logic [24:0]  prod_100;
  logic [24:0]  prod_10;
  logic [1:0]   q1000;
  logic [5:0]   q100;
  logic [8:0]   q10;
  logic [11:0]  units_full;
  logic [8:0]   tens_full;
  logic [5:0]   hund_full;

  assign s4_ready = !s4_ctl_r.vld || dn_ready;
  assign up_ready = s4_ready;

  // Quotients by 1000, 100 and 10 through scaled reciprocals
  assign prod_1000 = {13'd0, up_mv} * 25'd4195;
  assign prod_100  = {13'd0, up_mv} * 25'd5243;
  assign prod_10   = {13'd0, up_mv} * 25'd6554;
  assign q1000 = prod_1000[23:22];
  assign q100  = prod_100[24:19];
  assign q10   = prod_10[24:16];

  // Remainders give the lower digits
  assign units_full = up_mv - ({3'd0, q10} * 12'd10);
  assign tens_full  = q10 - ({3'd0, q100} * 9'd10);
  assign hund_full  = q100 - ({4'd0, q1000} * 6'd10);

  always_comb begin
    digits_nxt    = '0;
    digits_nxt[0] = units_full[3:0];
    digits_nxt[1] = tens_full[3:0];
    digits_nxt[2] = hund_full[3:0];
    digits_nxt[3] = {2'b00, q1000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (s4_ready) begin
      s4_ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) s4_digits_r <= digits_nxt;
  end

  assign dn_ctl    = s4_ctl_r;
  assign dn_digits = s4_digits_r;

endmodule

### sv/avd_display.sv
// Segment code store, scan position and the result register.
// Depends on avd_pkg; samples rewrite the codes, ticks read one and advance the scan.
module avd_display
  import avd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_D
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  avd_ctl_t             up_ctl,
  input  avd_digits_t          up_digits,
  output logic                 up_ready,
  output logic                 out_valid,
  output logic [SEG_W-1:0]     out_seg,
  output logic [SEL_OUT_W-1:0] out_sel,
  input  logic                 out_ready
);

  localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int SEL_W = (NUM_DIGITS > SEL_OUT_W) ? NUM_DIGITS : SEL_OUT_W;

  logic [SEG_W-1:0]     codes_r [NUM_DIGITS];
  logic [SEG_W-1:0]     codes_new [NUM_DIGITS];
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     pos_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [SEG_W-1:0]     out_seg_r;
  logic [SEL_OUT_W-1:0] out_sel_r;
  logic [SEL_W-1:0]     pos_onehot;
  logic                 out_free;
  logic                 tick_fire;
  logic                 code_wr;

  // A tick needs room in the result register, a sample never waits
  assign out_free  = !out_valid_r || out_ready;
  assign tick_fire = up_ctl.vld && up_ctl.tick && out_free;
  assign code_wr   = up_ctl.vld && !up_ctl.tick;
  assign up_ready  = !(up_ctl.vld && up_ctl.tick) || out_free;

  // Position i shows decimal digit NUM_DIGITS-1-i; digits past thousands are zero
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_code
    if (NUM_DIGITS - 1 - i < DIGITS_MAX) begin : g_live
      assign codes_new[i] = seg_code(up_digits[NUM_DIGITS-1-i]);
    end else begin : g_blank
      assign codes_new[i] = SEG_ZERO;
    end
  end

  // One-cold enable: bit NUM_DIGITS-1-pos goes low
  always_comb begin
    pos_onehot = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      pos_onehot[j] = (pos_r == POS_W'(NUM_DIGITS - 1 - j));
    end
  end

  assign pos_nxt = (pos_r == POS_W'(NUM_DIGITS - 1)) ? '0 : pos_r + 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold codes, scan position and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        codes_r[k] <= SEG_ZERO;
      end
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (code_wr) begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          codes_r[k] <= codes_new[k];
        end
      end
      if (tick_fire) pos_r <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_seg_r <= codes_r[pos_r];
      out_sel_r <= ~pos_onehot[SEL_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_seg   = out_seg_r;
  assign out_sel   = out_sel_r;

endmodule

### sv/avd_checker.sv
// Port-level checks for the voltmeter display, bound to the top level.
// Depends on avd_pkg and adc_voltmeter_display_scan.
module avd_checker
  import avd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_D
)
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Exactly one digit enabled, or none for positions beyond the fourth
  a_sel_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones(out_tdata[11:8]) == 3) ||
                   ((NUM_DIGITS > SEL_OUT_W) && (out_tdata[11:8] == 4'hf)))
    else $error("digit select not one-cold");

  // Decimal point stays off and padding stays zero
  a_seg_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] && (out_tdata[15:12] == 4'h0))
    else $error("decimal point lit or padding set");

  // Accept input beats whenever no result beat waits
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind adc_voltmeter_display_scan avd_checker #(.NUM_DIGITS(NUM_DIGITS)) u_avd_checker (.*);
